>>> design/assert_macros.svh
// Assertion helpers for the RTL. They compile to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define SAQ_ASSERT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define SAQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SAQ_ASSERT(lbl, clk, rst_n, ante, cons)
`define SAQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> design/saq_pkg.sv
package saq_pkg;

    localparam int CMD_BITS = 2;
    localparam int OUT_BITS = 8;
    // Extra headroom bits for span compares, enough for a span of up to 256.
    localparam int SPAN_GUARD = 9;

    localparam logic [CMD_BITS-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_QUERY = 2'd2;

endpackage

>>> design/saq_table.sv
module saq_table #(
    parameter int ADDR_BITS = 10,
    parameter int DATA_BITS = 168
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [DATA_BITS-1:0] i_wdata,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [DATA_BITS-1:0] o_rdata
);

    logic [DATA_BITS-1:0] r_mem [2**ADDR_BITS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data is registered: it belongs to the address of the previous cycle.
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> design/snapshot_ancestor_query_core.sv
// Node table with ancestor queries.
// Input channel (i_s_*): one command per transaction. The command kind travels in
// i_s_tuser (write entry, clear entry or ancestor query); the ids travel in i_s_tdata.
// Output channel (o_m_*): exactly one result per command, the ancestor_hit flag in
// bit 0 (always 0 for write, clear and the unused command).
// After reset the block sweeps the whole table to zero, one entry per cycle;
// o_s_tready stays low during that sweep.
// One command is handled at a time. All lookups run through the single read
// port of the table, whose read data is registered.
// States per command after it is accepted:
//   write: S_WOLD, then S_WCHK and S_WGET per ancestor found within NEAR_SPAN ids,
//     a last S_WCHK, then S_WRITE; clear: S_WRITE; unused command: straight on,
//   query: S_QCHK and S_QGET per jump taken, a last S_QCHK, then S_QBIT for a
//     bitmap test; a broken chain leaves from S_QGET. Every command ends in S_OUT.
// The result waits in the output register until o_m_tvalid meets i_m_tready;
// a stalled receiver holds the block, and the next command is taken the cycle
// after the result transaction completes.
`include "assert_macros.svh"
module snapshot_ancestor_query_core #(
    parameter int ID_BITS = 10,
    parameter int NEAR_SPAN = 128,
    localparam int IN_W = ((6 * ID_BITS + 7) / 8) * 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // node_id, parent, skip_low, skip_mid, skip_high, ancestor_id
    input  logic [IN_W-1:0]               i_s_tdata,
    // cmd
    input  logic [saq_pkg::CMD_BITS-1:0]  i_s_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // ancestor_hit
    output logic [saq_pkg::OUT_BITS-1:0]  o_m_tdata
);

    localparam int EW = NEAR_SPAN + 4 * ID_BITS;
    localparam int CW = ID_BITS + saq_pkg::SPAN_GUARD;
    localparam int IW = $clog2(NEAR_SPAN);
    localparam int NW = $clog2(NEAR_SPAN + 1);
    localparam int CB = saq_pkg::CMD_BITS;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_WOLD,
        S_WCHK,
        S_WGET,
        S_WRITE,
        S_QCHK,
        S_QGET,
        S_QBIT,
        S_OUT
    } t_state;

    t_state                 r_state;
    logic [ID_BITS-1:0]     r_clr;
    logic [CB-1:0]          r_cmd;
    logic [ID_BITS-1:0]     r_node;
    logic [ID_BITS-1:0]     r_par;
    logic [3*ID_BITS-1:0]   r_skips;
    logic [ID_BITS-1:0]     r_anc;
    logic [CW-1:0]          r_limit;
    logic [ID_BITS-1:0]     r_cur;
    logic [NEAR_SPAN-1:0]   r_bits;
    logic [NW-1:0]          r_cnt;
    logic                   r_ans;

    logic [CB-1:0]          f_cmd;
    logic [ID_BITS-1:0]     f_node;
    logic [ID_BITS-1:0]     f_par;
    logic [3*ID_BITS-1:0]   f_skips;
    logic [ID_BITS-1:0]     f_anc;

    logic                   mem_we;
    logic [ID_BITS-1:0]     mem_waddr;
    logic [EW-1:0]          mem_wdata;
    logic [ID_BITS-1:0]     mem_raddr;
    logic [EW-1:0]          mem_rdata;

    logic [NEAR_SPAN-1:0]   rd_bits;
    logic [ID_BITS-1:0]     rd_skip_low;
    logic [ID_BITS-1:0]     rd_skip_mid;
    logic [ID_BITS-1:0]     rd_skip_high;
    logic [ID_BITS-1:0]     rd_par;

    logic [CW-1:0]          w_diff;
    logic                   w_walk_ok;
    logic [ID_BITS-1:0]     w_nxt;
    logic                   w_qgo;
    logic                   w_qbit;
    logic [CW-1:0]          w_k;
    logic                   w_bit;
    logic [CW-1:0]          w_limit_in;

    assign f_cmd   = i_s_tuser;
    assign f_node  = i_s_tdata[0 +: ID_BITS];
    assign f_par   = i_s_tdata[ID_BITS +: ID_BITS];
    assign f_skips = i_s_tdata[2 * ID_BITS +: 3 * ID_BITS];
    assign f_anc   = i_s_tdata[5 * ID_BITS +: ID_BITS];

    // Entry layout, low bits first: bitmap, skip low, skip mid, skip high, parent.
    assign rd_bits      = mem_rdata[NEAR_SPAN-1:0];
    assign rd_skip_low  = mem_rdata[NEAR_SPAN +: ID_BITS];
    assign rd_skip_mid  = mem_rdata[NEAR_SPAN + ID_BITS +: ID_BITS];
    assign rd_skip_high = mem_rdata[NEAR_SPAN + 2 * ID_BITS +: ID_BITS];
    assign rd_par       = mem_rdata[NEAR_SPAN + 3 * ID_BITS +: ID_BITS];

    saq_table #(
        .ADDR_BITS (ID_BITS),
        .DATA_BITS (EW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        mem_raddr = (r_state == S_IDLE) ? f_node : r_cur;
        mem_we    = (r_state == S_CLEAR) || (r_state == S_WRITE);
        mem_waddr = (r_state == S_CLEAR) ? r_clr : r_node;
        if (r_state == S_WRITE && r_cmd == saq_pkg::CMD_WRITE) begin
            mem_wdata = {r_par, r_skips, r_bits};
        end else begin
            mem_wdata = '0;
        end
    end

    always_comb begin
        // Write walk: distance, less one, of the current ancestor above the written node.
        w_diff    = CW'(r_cur) - CW'(r_node) - CW'(1);
        w_walk_ok = (r_cur != '0) && (r_cur > r_node) && (w_diff < CW'(NEAR_SPAN))
                    && (r_cnt < NW'(NEAR_SPAN));

        // Query jump: the first of skip high, mid and low not above the ancestor, else the parent.
        if (rd_skip_high <= r_anc) begin
            w_nxt = rd_skip_high;
        end else if (rd_skip_mid <= r_anc) begin
            w_nxt = rd_skip_mid;
        end else if (rd_skip_low <= r_anc) begin
            w_nxt = rd_skip_low;
        end else begin
            w_nxt = rd_par;
        end

        w_qgo  = (r_cur != '0) && (CW'(r_cur) < r_limit);
        w_qbit = (r_cur != '0) && (r_cur < r_anc);
        w_k    = CW'(r_anc) - CW'(r_cur) - CW'(1);
        w_bit  = (w_k < CW'(NEAR_SPAN)) ? rd_bits[w_k[IW-1:0]] : 1'b0;

        // The threshold saturates at zero for ancestors close to the bottom.
        w_limit_in = (CW'(f_anc) > CW'(NEAR_SPAN)) ? CW'(f_anc) - CW'(NEAR_SPAN) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_cnt   <= '0;
            r_ans   <= 1'b0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + ID_BITS'(1);
                    if (r_clr == '1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_cmd   <= f_cmd;
                        r_node  <= f_node;
                        r_par   <= f_par;
                        r_skips <= f_skips;
                        r_anc   <= f_anc;
                        r_limit <= w_limit_in;
                        r_cur   <= f_node;
                        r_cnt   <= '0;
                        r_ans   <= 1'b0;
                        case (f_cmd)
                            saq_pkg::CMD_WRITE: r_state <= S_WOLD;
                            saq_pkg::CMD_CLEAR: r_state <= S_WRITE;
                            saq_pkg::CMD_QUERY: r_state <= S_QCHK;
                            default:            r_state <= S_OUT;
                        endcase
                    end
                end
                S_WOLD: begin
                    // A write keeps the bits the entry already holds.
                    r_bits  <= rd_bits;
                    r_cur   <= r_par;
                    r_state <= S_WCHK;
                end
                S_WCHK: begin
                    if (w_walk_ok) begin
                        r_bits[w_diff[IW-1:0]] <= 1'b1;
                        r_cnt                  <= r_cnt + NW'(1);
                        r_state                <= S_WGET;
                    end else begin
                        r_state <= S_WRITE;
                    end
                end
                S_WGET: begin
                    r_cur   <= rd_par;
                    r_state <= S_WCHK;
                end
                S_WRITE: begin
                    r_state <= S_OUT;
                end
                S_QCHK: begin
                    if (w_qgo) begin
                        r_state <= S_QGET;
                    end else if (w_qbit) begin
                        r_state <= S_QBIT;
                    end else begin
                        r_ans   <= (r_cur == r_anc);
                        r_state <= S_OUT;
                    end
                end
                S_QGET: begin
                    // A jump that does not climb means a broken chain.
                    if (w_nxt != '0 && w_nxt <= r_cur) begin
                        r_ans   <= 1'b0;
                        r_state <= S_OUT;
                    end else begin
                        r_cur   <= w_nxt;
                        r_state <= S_QCHK;
                    end
                end
                S_QBIT: begin
                    r_ans   <= w_bit;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_m_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = (r_state == S_OUT);
    assign o_m_tdata  = {{(saq_pkg::OUT_BITS - 1){1'b0}}, r_ans};

    `SAQ_ASSERT(a_one_side, i_clk, i_rst_n, o_s_tready, !o_m_tvalid)
    `SAQ_ASSERT(a_walk_bound, i_clk, i_rst_n, 1'b1, r_cnt <= NW'(NEAR_SPAN))
    `SAQ_ASSERT_NEXT(a_drain_ready, i_clk, i_rst_n, o_m_tvalid && i_m_tready, o_s_tready)
    `SAQ_ASSERT(a_query_climbs, i_clk, i_rst_n, $past(r_state) == S_QGET && r_state == S_QCHK,
                r_cur == '0 || r_cur > $past(r_cur))

endmodule
